// ----- rtl/mdtt_pkg.sv -----
// Package for the deadline timer table: request and response structs,
// operation and result codes, the cell control struct and the sequencer states.
`timescale 1ns / 1ps
package mdtt_pkg;
   localparam int NUM_SLOTS_DEF = 16;
   localparam int TIME_W = 48;
   localparam int PER_W = 32;
   localparam int MAX_FIRES = 16;
   localparam logic [9:0] MS_PER_SECOND = 10'd1000;
   localparam logic [7:0] CAUSE_REARM = 8'd0;
   localparam logic [7:0] CAUSE_TIME_SYNC = 8'd1;

   typedef enum logic [2:0] {
      MODE_REGISTER = 3'd0, MODE_CANCEL = 3'd1, MODE_RESCHED = 3'd2,
      MODE_SET_PERIOD = 3'd3, MODE_TICK = 3'd4, MODE_RESCHED_ALL = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      KIND_REGISTERED = 3'd0, KIND_FIRED = 3'd1, KIND_OK = 3'd2,
      KIND_ERROR = 3'd3, KIND_TICK_DONE = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_SCAN, ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [47:0] now_ms;
      logic [3:0]  slot;
      logic [31:0] period_ms;
      logic        fire_at_once;
      logic        repeat_req;
      logic [15:0] delay_seconds;
      logic [7:0]  cause;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] handle;
      logic [7:0] why;
      logic       last;
   } rsp_type;

   // Broadcast combinationally from the sequencer to every cell.
   typedef struct packed {
      logic        do_register;
      logic        do_cancel;
      logic        do_resched;
      logic        do_set_period;
      logic        do_resched_all;
      logic        do_catch_up;
      logic [47:0] now_ms;
      logic [47:0] new_deadline;
      logic [31:0] period_ms;
      logic        repeat_req;
      logic        fire_at_once;
      logic [7:0]  cause;
   } cell_cmd_type;
endpackage

// ----- rtl/multi_slot_deadline_timer_table.sv -----
// Top level of the deadline timer table: sequencer plus a chain of slot cells.
// Uses mdtt_pkg, mdtt_seq and mdtt_cell.
//
// A request is taken when start is high and busy is low. Register, cancel,
// reschedule, set period and reschedule all answer with one response in the
// following cycle, and busy stays low, so one such request per cycle is taken.
// A tick scans the slots one per cycle: fired responses (last low) come in
// slot order, then a tick-done response with last high; busy is high through
// the scan and the done state. The scan length is set by the sequencer's
// position counter, which ends the scan at the last slot.
// Each response stands for one cycle with rsp_strobe high; the receiver
// cannot stall it. Reset frees all slots, clears reason codes and rearms
// the catch-up of the first tick.
`timescale 1ns / 1ps
module multi_slot_deadline_timer_table import mdtt_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   cell_cmd_type cmd;
   logic [IDX_W-1:0] sel;
   logic token, fire_ok;
   logic [NUM_SLOTS-1:0] valid_vec, fire_vec, reg_grant;
   logic [NUM_SLOTS*8-1:0] why_vec;
   logic [NUM_SLOTS:0] chain;
   logic [IDX_W:0] scan_pos_unused;
   logic [IDX_W:0] pos_ff;

   assign scan_pos_unused = '0;
   // The token runs down the chain; chain[i] high means cell i is examined.
   always_ff @(posedge clock) begin
      if (reset || !token) pos_ff <= '0;
      else pos_ff <= pos_ff + 1'b1;
   end
   assign chain[0] = token && (pos_ff == scan_pos_unused);

   mdtt_seq #(.NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W)) u_seq (
      .clock(clock), .reset(reset), .start(start), .req(req_data), .busy(busy),
      .cmd(cmd), .sel(sel), .token(token), .fire_ok(fire_ok),
      .valid_vec(valid_vec), .fire_vec(fire_vec), .why_vec(why_vec),
      .reg_grant(reg_grant), .rsp_strobe(rsp_strobe), .rsp(rsp_data)
   );

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      mdtt_cell #(.IDX_W(IDX_W), .INDEX(IDX_W'(g))) u_cell (
         .clock(clock), .reset(reset), .cmd(cmd), .sel(sel),
         .reg_grant(reg_grant[g]), .token_in(chain[g] && token),
         .fire_ok(fire_ok), .token_out(chain[g+1]), .valid(valid_vec[g]),
         .fire(fire_vec[g]), .why(why_vec[g*8 +: 8])
      );
   end
endmodule

// ----- rtl/mdtt_cell.sv -----
// One timer slot of the chain. It applies broadcast commands and, during a
// tick scan, fires if it is armed and past its deadline when the scan token reaches it. Uses mdtt_pkg.
`timescale 1ns / 1ps
module mdtt_cell import mdtt_pkg::*; #(
   parameter int IDX_W = 4,
   parameter logic [IDX_W-1:0] INDEX = '0
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  logic [IDX_W-1:0] sel,
   input  logic         reg_grant,
   input  logic         token_in,
   input  logic         fire_ok,
   output logic         token_out,
   output logic         valid,
   output logic         fire,
   output logic [7:0]   why
);
   logic valid_ff, valid_in;
   logic token_ff;
   logic [47:0] deadline_ff, deadline_in, issued_ff, issued_in;
   logic [31:0] period_ff, period_in;
   logic periodic_ff, periodic_in;
   logic [7:0] reason_ff, reason_in;
   logic hit;

   assign hit = sel == INDEX;
   assign valid = valid_ff;
   assign why = reason_ff;
   // The scan token enters this cell in the cycle it is examined.
   assign fire = token_in && fire_ok && valid_ff && (cmd.now_ms > deadline_ff);
   assign token_out = token_ff;

   always_comb begin
      valid_in = valid_ff;
      deadline_in = deadline_ff;
      issued_in = issued_ff;
      period_in = period_ff;
      periodic_in = periodic_ff;
      reason_in = reason_ff;
      if (cmd.do_register && reg_grant) begin
         valid_in = 1'b1;
         issued_in = cmd.now_ms;
         period_in = cmd.period_ms;
         periodic_in = cmd.repeat_req;
         deadline_in = cmd.fire_at_once ? cmd.now_ms
                                        : cmd.now_ms + {16'd0, cmd.period_ms};
      end
      if (cmd.do_cancel && hit) valid_in = 1'b0;
      if (cmd.do_resched && hit) begin
         deadline_in = cmd.new_deadline;
         reason_in = cmd.cause;
      end
      if (cmd.do_set_period && hit) period_in = cmd.period_ms;
      if (cmd.do_resched_all && valid_ff) begin
         deadline_in = cmd.now_ms;
         reason_in = CAUSE_TIME_SYNC;
      end
      if (cmd.do_catch_up && valid_ff) begin
         deadline_in = deadline_ff + (cmd.now_ms - issued_ff);
         issued_in = cmd.now_ms;
      end
      if (fire) begin
         issued_in = cmd.now_ms;
         if (periodic_ff) begin
            deadline_in = deadline_ff + {16'd0, period_ff};
            reason_in = CAUSE_REARM;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         reason_ff <= '0;
         token_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         reason_ff <= reason_in;
         token_ff <= token_in;
      end
      deadline_ff <= deadline_in;
      issued_ff <= issued_in;
      period_ff <= period_in;
      periodic_ff <= periodic_in;
   end
endmodule

// ----- rtl/mdtt_seq.sv -----
// Sequencer: takes requests, drives the cell commands, walks the scan token
// and forms the responses. Uses mdtt_pkg.
`timescale 1ns / 1ps
module mdtt_seq import mdtt_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF,
   parameter int IDX_W = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_type      req,
   output logic         busy,
   output cell_cmd_type cmd,
   output logic [IDX_W-1:0] sel,
   output logic         token,
   output logic         fire_ok,
   input  logic [NUM_SLOTS-1:0] valid_vec,
   input  logic [NUM_SLOTS-1:0] fire_vec,
   input  logic [NUM_SLOTS*8-1:0] why_vec,
   output logic [NUM_SLOTS-1:0] reg_grant,
   output logic         rsp_strobe,
   output rsp_type      rsp
);
   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic first_done_ff, first_done_in;
   logic [IDX_W:0] pos_ff, pos_in;
   logic [4:0] fires_ff, fires_in;
   logic strobe_ff, strobe_in;
   rsp_type rsp_ff, rsp_in;
   logic [NUM_SLOTS-1:0] free_vec;
   logic in_range;
   logic [IDX_W-1:0] pos_idx;

   assign free_vec = ~valid_vec;
   assign reg_grant = free_vec & (~free_vec + 1'b1);
   assign in_range = 7'(req.slot) < 7'(NUM_SLOTS);
   assign busy = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp = rsp_ff;
   assign pos_idx = pos_ff[IDX_W-1:0];
   assign sel = IDX_W'(req.slot);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      first_done_in = first_done_ff;
      pos_in = pos_ff;
      fires_in = fires_ff;
      strobe_in = 1'b0;
      rsp_in = '0;
      rsp_in.last = 1'b1;
      cmd = '0;
      cmd.now_ms = req.now_ms;
      cmd.period_ms = req.period_ms;
      cmd.repeat_req = req.repeat_req;
      cmd.fire_at_once = req.fire_at_once;
      cmd.cause = req.cause;
      cmd.new_deadline = req.now_ms
                       + {22'd0, 26'(req.delay_seconds) * 26'(MS_PER_SECOND)};
      token = 1'b0;
      fire_ok = fires_ff < 5'(MAX_FIRES);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               strobe_in = 1'b1;
               unique case (req.mode)
                  MODE_REGISTER: begin
                     if (|free_vec) begin
                        cmd.do_register = 1'b1;
                        rsp_in.kind = KIND_REGISTERED;
                        for (int i = NUM_SLOTS - 1; i >= 0; i--)
                           if (free_vec[i]) rsp_in.handle = 4'(i);
                     end else rsp_in.kind = KIND_ERROR;
                  end
                  MODE_CANCEL: begin
                     cmd.do_cancel = in_range;
                     rsp_in.kind = in_range ? KIND_OK : KIND_ERROR;
                  end
                  MODE_RESCHED: begin
                     cmd.do_resched = in_range;
                     if (in_range) first_done_in = 1'b1;
                     rsp_in.kind = in_range ? KIND_OK : KIND_ERROR;
                  end
                  MODE_SET_PERIOD: begin
                     cmd.do_set_period = in_range && valid_vec[sel];
                     rsp_in.kind = cmd.do_set_period ? KIND_OK : KIND_ERROR;
                  end
                  MODE_RESCHED_ALL: begin
                     cmd.do_resched_all = 1'b1;
                     rsp_in.kind = KIND_OK;
                  end
                  MODE_TICK: begin
                     // The first tick after reset catches deadlines up, unless a reschedule came before it.
                     strobe_in = 1'b0;
                     cmd.do_catch_up = !first_done_ff;
                     first_done_in = 1'b1;
                     req_in = req;
                     pos_in = '0;
                     fires_in = '0;
                     state_in = ST_SCAN;
                  end
                  default: rsp_in.kind = KIND_ERROR;
               endcase
            end
         end
         ST_SCAN: begin
            // One cell is examined per cycle, the one at pos; token marks the scan as running.
            cmd.now_ms = req_ff.now_ms;
            token = 1'b1;
            if (fire_vec[pos_idx]) begin
               strobe_in = 1'b1;
               rsp_in.kind = KIND_FIRED;
               rsp_in.handle = 4'(pos_idx);
               rsp_in.why = why_vec[pos_idx*8 +: 8];
               rsp_in.last = 1'b0;
               fires_in = fires_ff + 5'd1;
            end
            pos_in = pos_ff + 1'b1;
            if (pos_ff == (IDX_W+1)'(NUM_SLOTS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            rsp_in.kind = KIND_TICK_DONE;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_done_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_done_ff <= first_done_in;
         strobe_ff <= strobe_in;
      end
      req_ff <= req_in;
      pos_ff <= pos_in;
      fires_ff <= fires_in;
      rsp_ff <= rsp_in;
   end
endmodule

// ----- sim/multi_slot_deadline_timer_table_checker.sv -----
// Response checker for the deadline timer table: predicts every response from the
// accepted requests and compares the responses as they appear. Uses mdtt_pkg.
`timescale 1ns / 1ps
module multi_slot_deadline_timer_table_checker import mdtt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req,
   input  logic    rsp_strobe,
   input  rsp_type rsp,
   output int      fail_count,
   output int      pending_count
);
   logic        armed [NUM_SLOTS_DEF];
   logic [47:0] due_ms [NUM_SLOTS_DEF];
   logic [47:0] issue_ms [NUM_SLOTS_DEF];
   logic [31:0] interval_ms [NUM_SLOTS_DEF];
   logic        repeats [NUM_SLOTS_DEF];
   logic [7:0]  reason_code [NUM_SLOTS_DEF];
   logic        caught_up;
   rsp_type     pending_responses [$];

   assign pending_count = pending_responses.size();

   task automatic push_response(input logic [2:0] kind, input logic [3:0] handle,
                                input logic [7:0] why, input logic last);
      rsp_type r;
      r.kind = kind;
      r.handle = handle;
      r.why = why;
      r.last = last;
      pending_responses.push_back(r);
   endtask

   task automatic predict_request(input req_type q);
      int free_idx;
      free_idx = -1;
      case (q.mode)
         MODE_REGISTER: begin
            for (int i = 0; i < NUM_SLOTS_DEF; i++)
               if (!armed[i] && free_idx < 0) free_idx = i;
            if (free_idx < 0) begin
               push_response(KIND_ERROR, 4'd0, 8'd0, 1'b1);
            end else begin
               armed[free_idx] = 1'b1;
               issue_ms[free_idx] = q.now_ms;
               interval_ms[free_idx] = q.period_ms;
               repeats[free_idx] = q.repeat_req;
               due_ms[free_idx] = q.fire_at_once ? q.now_ms : q.now_ms + {16'd0, q.period_ms};
               push_response(KIND_REGISTERED, free_idx[3:0], 8'd0, 1'b1);
            end
         end
         MODE_CANCEL: begin
            armed[q.slot] = 1'b0;
            push_response(KIND_OK, 4'd0, 8'd0, 1'b1);
         end
         MODE_RESCHED: begin
            due_ms[q.slot] = q.now_ms + {32'd0, q.delay_seconds} * 48'd1000;
            reason_code[q.slot] = q.cause;
            caught_up = 1'b1;
            push_response(KIND_OK, 4'd0, 8'd0, 1'b1);
         end
         MODE_SET_PERIOD: begin
            if (armed[q.slot]) begin
               interval_ms[q.slot] = q.period_ms;
               push_response(KIND_OK, 4'd0, 8'd0, 1'b1);
            end else begin
               push_response(KIND_ERROR, 4'd0, 8'd0, 1'b1);
            end
         end
         MODE_TICK: begin
            // The first tick shifts armed deadlines by the time since issue.
            if (!caught_up) begin
               caught_up = 1'b1;
               for (int i = 0; i < NUM_SLOTS_DEF; i++)
                  if (armed[i]) begin
                     due_ms[i] = due_ms[i] + (q.now_ms - issue_ms[i]);
                     issue_ms[i] = q.now_ms;
                  end
            end
            for (int i = 0; i < NUM_SLOTS_DEF; i++)
               if (armed[i] && q.now_ms > due_ms[i]) begin
                  issue_ms[i] = q.now_ms;
                  push_response(KIND_FIRED, i[3:0], reason_code[i], 1'b0);
                  if (repeats[i]) begin
                     due_ms[i] = due_ms[i] + {16'd0, interval_ms[i]};
                     reason_code[i] = CAUSE_REARM;
                  end else begin
                     armed[i] = 1'b0;
                  end
               end
            push_response(KIND_TICK_DONE, 4'd0, 8'd0, 1'b1);
         end
         MODE_RESCHED_ALL: begin
            for (int i = 0; i < NUM_SLOTS_DEF; i++)
               if (armed[i]) begin
                  due_ms[i] = q.now_ms;
                  reason_code[i] = CAUSE_TIME_SYNC;
               end
            push_response(KIND_OK, 4'd0, 8'd0, 1'b1);
         end
         default: push_response(KIND_ERROR, 4'd0, 8'd0, 1'b1);
      endcase
   endtask

   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (pending_responses.size() == 0) begin
         $error("unexpected response kind %0d handle %0d", got.kind, got.handle);
         fail_count++;
      end else begin
         want = pending_responses.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            fail_count++;
         end
         if (got.handle !== want.handle) begin
            $error("handle: expected %0d, actual %0d", want.handle, got.handle);
            fail_count++;
         end
         if (got.why !== want.why) begin
            $error("why: expected %0d, actual %0d", want.why, got.why);
            fail_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
         end
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
            armed[i] = 1'b0;
            due_ms[i] = '0;
            issue_ms[i] = '0;
            interval_ms[i] = '0;
            repeats[i] = 1'b0;
            reason_code[i] = '0;
         end
         caught_up = 1'b0;
         pending_responses.delete();
      end else begin
         if (rsp_strobe) check_response(rsp);
         if (start && !busy) predict_request(req);
      end
   end
endmodule

// ----- sim/multi_slot_deadline_timer_table_tb.sv -----
// Testbench top for the deadline timer table: clock, reset, directed and random
// requests and the verdict. Uses mdtt_pkg and multi_slot_deadline_timer_table_checker.
`timescale 1ns / 1ps
module multi_slot_deadline_timer_table_tb;
   import mdtt_pkg::*;

   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp;
   int      fail_count;
   int      pending_count;
   int      cycle_count;
   logic [47:0] clock_ms;

   multi_slot_deadline_timer_table u_dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req),
      .busy(busy), .rsp_strobe(rsp_strobe), .rsp_data(rsp)
   );

   multi_slot_deadline_timer_table_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_strobe(rsp_strobe), .rsp(rsp),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_type make_req(input logic [2:0] mode, input logic [47:0] now,
                                        input logic [3:0] slot, input logic [31:0] per,
                                        input logic at_once, input logic rep,
                                        input logic [15:0] delay, input logic [7:0] cause);
      req_type r;
      r.mode = mode;
      r.now_ms = now;
      r.slot = slot;
      r.period_ms = per;
      r.fire_at_once = at_once;
      r.repeat_req = rep;
      r.delay_seconds = delay;
      r.cause = cause;
      return r;
   endfunction

   function automatic logic [47:0] any_time();
      return {$urandom, 16'($urandom)};
   endfunction

   // Holds the request until it is taken, then idles for a random gap, which may be zero.
   task automatic send(input req_type r);
      int gap;
      start <= 1'b1;
      req <= r;
      do @(posedge clock); while (busy);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
            ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int sel;
      logic [31:0] per;
      logic [3:0] r_slot;
      logic r_once;
      logic r_rep;
      logic [15:0] r_delay;
      logic [7:0] r_cause;
      start = 1'b0;
      req = '0;
      reset = 1'b1;
      clock_ms = 48'd5000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill the table, overflow it, then walk every operation.
      send(make_req(MODE_REGISTER, 48'd0, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'd0, 8'd0));
      send(make_req(MODE_REGISTER, 48'hFFFF_FFFF_FFFF, 4'd0, 32'd0, 1'b1, 1'b0, 16'd0, 8'd0));
      for (int i = 2; i < NUM_SLOTS_DEF; i++)
         send(make_req(MODE_REGISTER, 48'd100 * i, 4'd0, 32'd10 * i, i[0], i[1], 16'd0, 8'd0));
      send(make_req(MODE_REGISTER, 48'd2000, 4'd0, 32'd5, 1'b0, 1'b0, 16'd0, 8'd0));
      // First tick applies the catch-up shift before firing.
      send(make_req(MODE_TICK, clock_ms, 4'd0, 32'd0, 1'b0, 1'b0, 16'd0, 8'd0));
      send(make_req(MODE_RESCHED, clock_ms, 4'd15, 32'd0, 1'b0, 1'b0, 16'hFFFF, 8'hFF));
      send(make_req(MODE_SET_PERIOD, clock_ms, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 8'd0));
      send(make_req(MODE_CANCEL, clock_ms, 4'd0, 32'd0, 1'b0, 1'b0, 16'd0, 8'd0));
      send(make_req(MODE_SET_PERIOD, clock_ms, 4'd0, 32'd7, 1'b0, 1'b0, 16'd0, 8'd0));
      send(make_req(MODE_RESCHED_ALL, clock_ms, 4'd0, 32'd0, 1'b0, 1'b0, 16'd0, 8'd0));
      send(make_req(MODE_TICK, clock_ms + 48'd1, 4'd0, 32'd0, 1'b0, 1'b0, 16'd0, 8'd0));
      send(make_req(MODE_SPARE_A, clock_ms, 4'd3, 32'd0, 1'b1, 1'b1, 16'd1, 8'd1));
      send(make_req(MODE_SPARE_B, clock_ms, 4'd3, 32'd0, 1'b1, 1'b1, 16'd1, 8'd1));

      // Random: mostly a forward-moving clock with frequent ticks, some time jumps.
      for (int n = 0; n < 100; n++) begin
         sel = $urandom_range(0, 99);
         clock_ms = clock_ms + 48'($urandom_range(0, 3000));
         per = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 5000);
         r_slot = 4'($urandom);
         r_once = 1'($urandom);
         r_rep = 1'($urandom);
         r_delay = 16'($urandom);
         r_cause = 8'($urandom);
         if (sel < 30)
            send(make_req(MODE_TICK, clock_ms, r_slot, $urandom, r_once, r_rep,
                          r_delay, r_cause));
         else if (sel < 50)
            send(make_req(MODE_REGISTER, clock_ms, r_slot, per, r_once, r_rep,
                          r_delay, r_cause));
         else if (sel < 60)
            send(make_req(MODE_CANCEL, clock_ms, r_slot, per, r_once, r_rep,
                          r_delay, r_cause));
         else if (sel < 72)
            send(make_req(MODE_RESCHED, clock_ms, r_slot, per, r_once, r_rep,
                          ($urandom_range(0, 4) == 0) ? r_delay
                                                      : 16'($urandom_range(0, 3)),
                          r_cause));
         else if (sel < 82)
            send(make_req(MODE_SET_PERIOD, clock_ms, r_slot, per, r_once, r_rep,
                          r_delay, r_cause));
         else if (sel < 88)
            send(make_req(MODE_RESCHED_ALL, clock_ms, r_slot, per, r_once, r_rep,
                          r_delay, r_cause));
         else if (sel < 92)
            send(make_req($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B, any_time(),
                          r_slot, $urandom, r_once, r_rep, r_delay, r_cause));
         else begin
            clock_ms = any_time();
            send(make_req(MODE_TICK, clock_ms, r_slot, $urandom, r_once, r_rep,
                          r_delay, r_cause));
         end
      end
      start <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (2 * NUM_SLOTS_DEF + 4) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/mdtt_pkg.sv
rtl/mdtt_cell.sv
rtl/mdtt_seq.sv
rtl/multi_slot_deadline_timer_table.sv
sim/multi_slot_deadline_timer_table_checker.sv
sim/multi_slot_deadline_timer_table_tb.sv
